### rtl/css_pkg.sv
// conveyor sort sequencer: shared types, codes and reset constants
// used by css_cfg_regs, css_fsm and conveyor_sort_sequencer_core; no dependencies
`timescale 1ns / 1ps

package css_pkg;

	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int TIMER_BITS_DEF = 16;

	localparam logic [CFG_W-1:0] SCAN_INTERVAL_RST = 16'd30;
	localparam logic [CFG_W-1:0] NUDGE_RST         = 16'd5;
	localparam logic [CFG_W-1:0] BIN_TIMEOUT_RST   = 16'd50;
	localparam logic [CFG_W-1:0] CONFIRM_HOLD_RST  = 16'd60;
	localparam logic [CFG_W-1:0] REJECT_TIMEOUT_RST = 16'd100;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SCAN = 3'd1,
		PH_DROP = 3'd2,
		PH_CONF = 3'd3,
		PH_REJ  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		MOT_STOP = 2'd0,
		MOT_SCAN = 2'd1,
		MOT_FAST = 2'd2,
		MOT_REV  = 2'd3
	} motor_t;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_APPROVE = 2'd1,
		REQ_REJECT  = 2'd2
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCAN_INTERVAL  = 3'd0,
		CFG_NUDGE          = 3'd1,
		CFG_BIN_TIMEOUT    = 3'd2,
		CFG_CONFIRM_HOLD   = 3'd3,
		CFG_REJECT_TIMEOUT = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] scan_interval;
		logic [CFG_W-1:0] nudge;
		logic [CFG_W-1:0] bin_timeout;
		logic [CFG_W-1:0] confirm_hold;
		logic [CFG_W-1:0] reject_timeout;
	} css_cfg_t;

	typedef struct packed {
		phase_t phase;
		motor_t motor;
		logic   bin_ok;
		logic   nudge_active;
	} css_res_t;

endpackage

### rtl/css_cfg_regs.sv
// conveyor sort sequencer: configuration register file
// depends on css_pkg
`timescale 1ns / 1ps

module css_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [css_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [css_pkg::CFG_W-1:0]     wr_data,
	output css_pkg::css_cfg_t             cfg
);

	css_pkg::css_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_interval  <= css_pkg::SCAN_INTERVAL_RST;
			cfg_q.nudge          <= css_pkg::NUDGE_RST;
			cfg_q.bin_timeout    <= css_pkg::BIN_TIMEOUT_RST;
			cfg_q.confirm_hold   <= css_pkg::CONFIRM_HOLD_RST;
			cfg_q.reject_timeout <= css_pkg::REJECT_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (css_pkg::cfg_idx_t'(wr_index))
				css_pkg::CFG_SCAN_INTERVAL:  cfg_q.scan_interval  <= wr_data;
				css_pkg::CFG_NUDGE:          cfg_q.nudge          <= wr_data;
				css_pkg::CFG_BIN_TIMEOUT:    cfg_q.bin_timeout    <= wr_data;
				css_pkg::CFG_CONFIRM_HOLD:   cfg_q.confirm_hold   <= wr_data;
				css_pkg::CFG_REJECT_TIMEOUT: cfg_q.reject_timeout <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/css_fsm.sv
// conveyor sort sequencer: phase machine, phase timer and pending flags
// depends on css_pkg
`timescale 1ns / 1ps

module css_fsm #(
	parameter int TIMER_BITS = css_pkg::TIMER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [1:0]        req_type,
	input  logic              entrance,
	input  logic              bin,
	input  css_pkg::css_cfg_t cfg,
	output css_pkg::css_res_t res
);

	localparam int CMP_W = (TIMER_BITS > css_pkg::CFG_W) ? TIMER_BITS : css_pkg::CFG_W;

	css_pkg::phase_t        phase_q, phase_d;
	css_pkg::motor_t        motor_q, motor_d;
	logic [TIMER_BITS-1:0]  timer_q, timer_d;
	logic                   nudge_q, nudge_d;
	logic                   appr_q, appr_d;
	logic                   rej_q, rej_d;
	logic                   conf_q, conf_d;

	logic [TIMER_BITS-1:0]     timer_inc;
	logic [css_pkg::CFG_W-1:0] limit;
	logic                      reached;

	// saturating count; a limit above the timer range expires at saturation
	always_comb begin
		timer_inc = (timer_q == '1) ? timer_q : timer_q + 1'b1;
		unique case (phase_q)
			css_pkg::PH_SCAN: limit = nudge_q ? cfg.nudge : cfg.scan_interval;
			css_pkg::PH_DROP: limit = cfg.bin_timeout;
			css_pkg::PH_CONF: limit = cfg.confirm_hold;
			css_pkg::PH_REJ:  limit = cfg.reject_timeout;
			default:          limit = cfg.reject_timeout;
		endcase
		reached = (CMP_W'(timer_inc) >= CMP_W'(limit)) || (timer_inc == '1);
	end

	always_comb begin
		phase_d = phase_q;
		motor_d = motor_q;
		timer_d = timer_q;
		nudge_d = nudge_q;
		appr_d  = appr_q;
		rej_d   = rej_q;
		conf_d  = conf_q;
		unique case (css_pkg::req_t'(req_type))
			css_pkg::REQ_TICK: begin
				unique case (phase_q)
					css_pkg::PH_IDLE: begin
						if (entrance) begin
							conf_d  = 1'b0;
							motor_d = css_pkg::MOT_SCAN;
							nudge_d = 1'b0;
							timer_d = '0;
							phase_d = css_pkg::PH_SCAN;
						end
					end
					css_pkg::PH_SCAN: begin
						priority if (nudge_q) begin
							timer_d = timer_inc;
							if (reached) begin
								motor_d = css_pkg::MOT_STOP;
								nudge_d = 1'b0;
								timer_d = '0;
							end
						end else if (appr_q) begin
							appr_d  = 1'b0;
							motor_d = css_pkg::MOT_FAST;
							timer_d = '0;
							phase_d = css_pkg::PH_DROP;
						end else if (rej_q) begin
							rej_d   = 1'b0;
							motor_d = css_pkg::MOT_REV;
							timer_d = '0;
							phase_d = css_pkg::PH_REJ;
						end else begin
							timer_d = timer_inc;
							if (reached) begin
								nudge_d = 1'b1;
								motor_d = css_pkg::MOT_SCAN;
								timer_d = '0;
							end
						end
					end
					css_pkg::PH_DROP: begin
						if (bin) begin
							motor_d = css_pkg::MOT_STOP;
							conf_d  = 1'b1;
							timer_d = '0;
							phase_d = css_pkg::PH_CONF;
						end else begin
							timer_d = timer_inc;
							if (reached) begin
								motor_d = css_pkg::MOT_STOP;
								conf_d  = 1'b0;
								timer_d = '0;
								phase_d = css_pkg::PH_CONF;
							end
						end
					end
					css_pkg::PH_CONF: begin
						timer_d = timer_inc;
						if (reached) begin
							motor_d = css_pkg::MOT_STOP;
							appr_d  = 1'b0;
							rej_d   = 1'b0;
							nudge_d = 1'b0;
							timer_d = '0;
							phase_d = css_pkg::PH_IDLE;
						end
					end
					default: begin
						// rejecting, and any stray code falls back to idle the same way
						if (phase_q == css_pkg::PH_REJ && entrance) begin
							timer_d = timer_inc;
						end
						if (phase_q != css_pkg::PH_REJ || !entrance || reached) begin
							motor_d = css_pkg::MOT_STOP;
							appr_d  = 1'b0;
							rej_d   = 1'b0;
							nudge_d = 1'b0;
							timer_d = '0;
							phase_d = css_pkg::PH_IDLE;
						end
					end
				endcase
			end
			css_pkg::REQ_APPROVE: appr_d = 1'b1;
			css_pkg::REQ_REJECT:  rej_d  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= css_pkg::PH_IDLE;
			motor_q <= css_pkg::MOT_STOP;
			timer_q <= '0;
			nudge_q <= 1'b0;
			appr_q  <= 1'b0;
			rej_q   <= 1'b0;
			conf_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			motor_q <= motor_d;
			timer_q <= timer_d;
			nudge_q <= nudge_d;
			appr_q  <= appr_d;
			rej_q   <= rej_d;
			conf_q  <= conf_d;
		end
	end

	always_comb begin
		res.phase        = phase_d;
		res.motor        = motor_d;
		res.bin_ok       = conf_d;
		res.nudge_active = nudge_d;
	end

	// a nudge only runs while scanning
	a_nudge_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		nudge_q |-> (phase_q == css_pkg::PH_SCAN))
		else $error("nudge outside scanning");

	// idle and confirming keep the conveyor stopped
	a_stop_when_still: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == css_pkg::PH_IDLE || phase_q == css_pkg::PH_CONF)
		|-> (motor_q == css_pkg::MOT_STOP))
		else $error("motor running in idle or confirming");

	// dropping runs fast, rejecting reverses
	a_motor_drop_rej: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == css_pkg::PH_DROP) |-> (motor_q == css_pkg::MOT_FAST)) and
		((phase_q == css_pkg::PH_REJ) |-> (motor_q == css_pkg::MOT_REV)))
		else $error("motor mode does not match phase");

	// state only moves on an item
	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(phase_q) && $stable(timer_q) && $stable(appr_q) && $stable(rej_q)))
		else $error("state changed without an item");

endmodule

### rtl/conveyor_sort_sequencer_core.sv
// conveyor sort sequencer top level: input register, phase machine, result register
// depends on css_pkg, css_cfg_regs and css_fsm
`timescale 1ns / 1ps

// channel   signals                                        direction
// in        in_valid / in_ready, req_type,                 request into the block
//           entrance_present, bin_present
// out       out_valid / out_ready, state_code,             one result per request
//           motor_mode, bin_ok, nudge_active
// cfg       cfg_valid / cfg_ready, cfg_index, cfg_data     register writes, always ready
//
// one request per clock sustained while out_ready holds; after acceptance a request is held
// in the input register and its result moves to the result register when that slot is free
// the single state update between the two registers happens once per request
// stalls on out back up through the result and input registers to in_ready combinationally
// reset clears valids, phase machine, flags and timer, and loads register defaults
// register writes take effect on the next clock; cfg_index values past the list are ignored

module conveyor_sort_sequencer_core #(
	parameter int TIMER_BITS = css_pkg::TIMER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic                          entrance_present,
	input  logic                          bin_present,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    state_code,
	output logic [1:0]                    motor_mode,
	output logic                          bin_ok,
	output logic                          nudge_active,
	// configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [css_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [css_pkg::CFG_W-1:0]     cfg_data
);

	// input register
	logic       valid_s1;
	logic [1:0] req_s1;
	logic       ent_s1;
	logic       bin_s1;

	// result register
	logic              out_valid_q;
	css_pkg::css_res_t res_q;

	css_pkg::css_cfg_t cfg;
	css_pkg::css_res_t res_next;
	logic              advance;

	// the request in the input register moves on when the result slot is free or draining
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	css_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	css_fsm #(
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.req_type (req_s1),
		.entrance (ent_s1),
		.bin      (bin_s1),
		.cfg      (cfg),
		.res      (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= req_type;
			ent_s1 <= entrance_present;
			bin_s1 <= bin_present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign state_code   = res_q.phase;
	assign motor_mode   = res_q.motor;
	assign bin_ok       = res_q.bin_ok;
	assign nudge_active = res_q.nudge_active;

endmodule

### verif/css_status_checker.sv
// conveyor sort sequencer checker: watches the request, result and register channels,
// predicts each status result and compares it with the block; depends on css_pkg
`timescale 1ns / 1ps

module css_status_checker #(
	parameter int TIMER_BITS = css_pkg::TIMER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic                          entrance_present,
	input  logic                          bin_present,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [2:0]                    state_code,
	input  logic [1:0]                    motor_mode,
	input  logic                          bin_ok,
	input  logic                          nudge_active,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [css_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [css_pkg::CFG_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending_count
);

	localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 1);

	css_pkg::css_cfg_t     seq_cfg;
	css_pkg::phase_t       seq_phase;
	css_pkg::motor_t       seq_motor;
	logic [TIMER_BITS-1:0] seq_timer;
	logic                  seq_nudge;
	logic                  seq_approve;
	logic                  seq_reject;
	logic                  seq_confirmed;

	css_pkg::css_res_t expected_status_q[$];
	css_pkg::css_res_t want;

	// saturating count, limit clamped to the timer range
	function automatic logic timer_expired(input logic [css_pkg::CFG_W-1:0] limit);
		logic [31:0] lim;
		if (32'(seq_timer) < TIMER_MAX)
			seq_timer = seq_timer + 1'b1;
		lim = 32'(limit);
		if (lim > TIMER_MAX)
			lim = TIMER_MAX;
		return 32'(seq_timer) >= lim;
	endfunction

	function automatic void enter_idle();
		seq_motor   = css_pkg::MOT_STOP;
		seq_approve = 1'b0;
		seq_reject  = 1'b0;
		seq_nudge   = 1'b0;
		seq_timer   = '0;
		seq_phase   = css_pkg::PH_IDLE;
	endfunction

	function automatic void advance_tick(input logic ent, input logic bin);
		case (seq_phase)
			css_pkg::PH_IDLE: begin
				if (ent) begin
					seq_confirmed = 1'b0;
					seq_motor     = css_pkg::MOT_SCAN;
					seq_nudge     = 1'b0;
					seq_timer     = '0;
					seq_phase     = css_pkg::PH_SCAN;
				end
			end
			css_pkg::PH_SCAN: begin
				if (seq_nudge) begin
					if (timer_expired(seq_cfg.nudge)) begin
						seq_motor = css_pkg::MOT_STOP;
						seq_nudge = 1'b0;
						seq_timer = '0;
					end
				end else if (seq_approve) begin
					seq_approve = 1'b0;
					seq_motor   = css_pkg::MOT_FAST;
					seq_timer   = '0;
					seq_phase   = css_pkg::PH_DROP;
				end else if (seq_reject) begin
					seq_reject = 1'b0;
					seq_motor  = css_pkg::MOT_REV;
					seq_timer  = '0;
					seq_phase  = css_pkg::PH_REJ;
				end else if (timer_expired(seq_cfg.scan_interval)) begin
					seq_nudge = 1'b1;
					seq_motor = css_pkg::MOT_SCAN;
					seq_timer = '0;
				end
			end
			css_pkg::PH_DROP: begin
				if (bin) begin
					seq_motor     = css_pkg::MOT_STOP;
					seq_confirmed = 1'b1;
					seq_timer     = '0;
					seq_phase     = css_pkg::PH_CONF;
				end else if (timer_expired(seq_cfg.bin_timeout)) begin
					seq_motor     = css_pkg::MOT_STOP;
					seq_confirmed = 1'b0;
					seq_timer     = '0;
					seq_phase     = css_pkg::PH_CONF;
				end
			end
			css_pkg::PH_CONF: begin
				if (timer_expired(seq_cfg.confirm_hold))
					enter_idle();
			end
			css_pkg::PH_REJ: begin
				if (!ent || timer_expired(seq_cfg.reject_timeout))
					enter_idle();
			end
			default: enter_idle();
		endcase
	endfunction

	function automatic css_pkg::css_res_t predict_status(input logic [1:0] req,
			input logic ent, input logic bin);
		css_pkg::css_res_t r;
		case (req)
			css_pkg::REQ_TICK:    advance_tick(ent, bin);
			css_pkg::REQ_APPROVE: seq_approve = 1'b1;
			css_pkg::REQ_REJECT:  seq_reject = 1'b1;
			default: ;
		endcase
		r.phase        = seq_phase;
		r.motor        = seq_motor;
		r.bin_ok       = seq_confirmed;
		r.nudge_active = seq_nudge;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_cfg.scan_interval  = css_pkg::SCAN_INTERVAL_RST;
			seq_cfg.nudge          = css_pkg::NUDGE_RST;
			seq_cfg.bin_timeout    = css_pkg::BIN_TIMEOUT_RST;
			seq_cfg.confirm_hold   = css_pkg::CONFIRM_HOLD_RST;
			seq_cfg.reject_timeout = css_pkg::REJECT_TIMEOUT_RST;
			seq_confirmed          = 1'b0;
			enter_idle();
			expected_status_q.delete();
			fail_count    = 0;
			pending_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					css_pkg::CFG_SCAN_INTERVAL:  seq_cfg.scan_interval = cfg_data;
					css_pkg::CFG_NUDGE:          seq_cfg.nudge = cfg_data;
					css_pkg::CFG_BIN_TIMEOUT:    seq_cfg.bin_timeout = cfg_data;
					css_pkg::CFG_CONFIRM_HOLD:   seq_cfg.confirm_hold = cfg_data;
					css_pkg::CFG_REJECT_TIMEOUT: seq_cfg.reject_timeout = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_status_q.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					want = expected_status_q.pop_front();
					if (state_code !== want.phase) begin
						$error("state_code: expected %0d, actual %0d", want.phase, state_code);
						fail_count++;
					end
					if (motor_mode !== want.motor) begin
						$error("motor_mode: expected %0d, actual %0d", want.motor, motor_mode);
						fail_count++;
					end
					if (bin_ok !== want.bin_ok) begin
						$error("bin_ok: expected %0d, actual %0d", want.bin_ok, bin_ok);
						fail_count++;
					end
					if (nudge_active !== want.nudge_active) begin
						$error("nudge_active: expected %0d, actual %0d", want.nudge_active,
							nudge_active);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_status_q.push_back(predict_status(req_type, entrance_present,
					bin_present));
			pending_count = expected_status_q.size();
		end
	end

endmodule

### verif/tb_top.sv
// conveyor sort sequencer testbench top: clock, reset, request and register stimulus,
// receiver stalls and verdict; depends on css_pkg, css_status_checker and the core
`timescale 1ns / 1ps

module tb_top;

	typedef logic [css_pkg::CFG_IDX_W-1:0] cfg_index_t;
	typedef logic [css_pkg::CFG_W-1:0]     cfg_word_t;

	// code the block must ignore on the request channel
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 300000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] req_type = css_pkg::REQ_TICK;
	logic       entrance_present = 1'b0;
	logic       bin_present = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] state_code;
	logic [1:0] motor_mode;
	logic       bin_ok;
	logic       nudge_active;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_index_t cfg_index = '0;
	cfg_word_t  cfg_data = '0;

	int fail_count;
	int pending_count;
	int cycle_count = 0;
	int requests_sent = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	// two delays, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	conveyor_sort_sequencer_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.entrance_present (entrance_present),
		.bin_present      (bin_present),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.state_code       (state_code),
		.motor_mode       (motor_mode),
		.bin_ok           (bin_ok),
		.nudge_active     (nudge_active),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	css_status_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.entrance_present (entrance_present),
		.bin_present      (bin_present),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.state_code       (state_code),
		.motor_mode       (motor_mode),
		.bin_ok           (bin_ok),
		.nudge_active     (nudge_active),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.pending_count    (pending_count)
	);

	// receiver: runs of steady ready, random ready, light stalls and full stalls
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 48);
		end
		stall_left--;
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			2:       out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= 1'b0;
		endcase
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("conveyor_sort_sequencer_core: mismatch");
			$finish;
		end
	end

	// one request; the sender runs in bursts with random gaps between them
	task automatic send_request(input logic [1:0] req, input logic ent, input logic bin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
			burst_left = $urandom_range(1, 24);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid         <= 1'b1;
		req_type         <= req;
		entrance_present <= ent;
		bin_present      <= bin;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		if (req != REQ_SPARE)
			requests_sent++;
	endtask

	task automatic send_tick(input logic ent, input logic bin);
		send_request(css_pkg::REQ_TICK, ent, bin);
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_count != 0)
			@(negedge clk);
		// two-stage pipe, then an idle margin
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input cfg_word_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(input cfg_word_t scan, input cfg_word_t nudge,
			input cfg_word_t bin_to, input cfg_word_t hold, input cfg_word_t rej_to);
		write_reg(css_pkg::CFG_SCAN_INTERVAL, scan);
		write_reg(css_pkg::CFG_NUDGE, nudge);
		write_reg(css_pkg::CFG_BIN_TIMEOUT, bin_to);
		write_reg(css_pkg::CFG_CONFIRM_HOLD, hold);
		write_reg(css_pkg::CFG_REJECT_TIMEOUT, rej_to);
	endtask

	// one bottle through the sorter: arrival, scan, a verdict, then drop or reversal
	task automatic run_bottle();
		int choice;
		repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'($urandom_range(0, 1)));
		send_tick(1'b1, 1'($urandom_range(0, 1)));
		repeat ($urandom_range(0, 8))
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		choice = $urandom_range(0, 19);
		if (choice < 10) begin
			send_request(css_pkg::REQ_APPROVE, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else if (choice < 17) begin
			send_request(css_pkg::REQ_REJECT, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		end else begin
			// both verdicts, either order: approve must still win
			if (choice[0]) begin
				send_request(css_pkg::REQ_REJECT, 1'b0, 1'b0);
				send_request(css_pkg::REQ_APPROVE, 1'b1, 1'b1);
			end else begin
				send_request(css_pkg::REQ_APPROVE, 1'b0, 1'b1);
				send_request(css_pkg::REQ_REJECT, 1'b1, 1'b0);
			end
		end
		repeat ($urandom_range(2, 20))
			send_tick($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 6))
			send_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
	endtask

	task automatic run_random(input int count);
		int target;
		target = requests_sent + count;
		while (requests_sent < target) begin
			if ($urandom_range(0, 3) != 0)
				run_bottle();
			else
				run_noise();
		end
	endtask

	initial begin
		int idx;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// short limits so the directed walk reaches every phase
		set_limits(16'd2, 16'd1, 16'd3, 16'd2, 16'd3);

		// unused code and verdicts latched while idle
		send_request(REQ_SPARE, 1'b1, 1'b1);
		send_request(css_pkg::REQ_APPROVE, 1'b0, 1'b0);
		send_request(css_pkg::REQ_REJECT, 1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		// arrival, approve taken ahead of reject, bin sensor confirms
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		// confirm hold, idle clears the stale reject
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		// nudge with an approve deferred until it ends
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_request(css_pkg::REQ_APPROVE, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		// drop runs out without the bin sensor
		repeat (3) send_tick(1'b1, 1'b0);
		repeat (2) send_tick(1'b0, 1'b0);
		// reversal cut short by the entrance clearing
		send_tick(1'b1, 1'b0);
		send_request(css_pkg::REQ_REJECT, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		drain_results();

		// limits of one
		set_limits(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		run_random(120);
		drain_results();

		// zero limits expire on the first counted tick
		set_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_random(70);
		drain_results();

		// largest limits, plus writes to indexes past the list which must be ignored
		set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		for (idx = int'(css_pkg::CFG_REJECT_TIMEOUT) + 1; idx < (1 << css_pkg::CFG_IDX_W);
				idx++)
			write_reg(idx[css_pkg::CFG_IDX_W-1:0], cfg_word_t'($urandom));
		run_random(40);
		drain_results();

		// a few mixed short settings
		repeat (4) begin
			set_limits(cfg_word_t'($urandom_range(1, 12)), cfg_word_t'($urandom_range(1, 12)),
				cfg_word_t'($urandom_range(1, 12)), cfg_word_t'($urandom_range(1, 12)),
				cfg_word_t'($urandom_range(1, 12)));
			run_random(55);
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("conveyor_sort_sequencer_core: match");
		else
			$display("conveyor_sort_sequencer_core: mismatch");
		$finish;
	end

endmodule
